// ===== rtl/sfpd_pkg.sv =====
package sfpd_pkg;

	localparam int FRAME_BYTES_DEF     = 1024;
	localparam int PACKET_OVERHEAD_DEF = 3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_START  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PACKET_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_MASK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STREAM_MASK  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET   = 3'd4;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TRUNCATED = 3'd1,
		ST_TOO_LONG  = 3'd2,
		ST_TRAILING  = 3'd3,
		ST_SKIPPED   = 3'd4
	} frame_status_t;

	typedef struct packed {
		logic [7:0]  frame_start_byte;
		logic [7:0]  packet_start_byte;
		logic [15:0] length_field_mask;
		logic [15:0] stream_flag_mask;
		logic [15:0] max_packet_bytes;
	} sfpd_cfg_t;

	localparam sfpd_cfg_t CFG_RESET = '{
		frame_start_byte:  8'd85,
		packet_start_byte: 8'd170,
		length_field_mask: 16'd16383,
		stream_flag_mask:  16'd32768,
		max_packet_bytes:  16'd1024
	};

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_begin;
	} sfpd_in_t;

	typedef struct packed {
		logic [7:0]    payload_byte;
		logic          byte_valid;
		logic          packet_first;
		logic          packet_last;
		logic          stream_packet;
		logic          frame_done;
		frame_status_t frame_status;
	} sfpd_out_t;

endpackage

// ===== rtl/sfpd_parser.sv =====
module sfpd_parser import sfpd_pkg::*; #(
	parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
	parameter int PACKET_OVERHEAD = PACKET_OVERHEAD_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  sfpd_cfg_t cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  sfpd_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output sfpd_out_t out_data
);

	localparam int LEFT_W = $clog2(FRAME_BYTES);
	localparam int PAD_W  = $clog2(PACKET_OVERHEAD);

	typedef enum logic [2:0] {
		PH_IDLE, PH_FLEN_LO, PH_FLEN_HI, PH_SOP, PH_HDR_LO, PH_HDR_HI, PH_PAD, PH_DATA
	} phase_t;

	phase_t            ph_q, ph_d;
	logic [LEFT_W-1:0] left_q, left_d;
	logic [LEFT_W-1:0] pay_q, pay_d;
	logic [7:0]        lo_q, lo_d;
	logic [PAD_W-1:0]  pad_q, pad_d;
	logic              stream_q, stream_d;
	logic              started_q, started_d;
	logic              out_valid_q;
	sfpd_out_t         out_data_q;

	logic              fire;
	logic              emit;
	sfpd_out_t         res;
	logic              do_after;
	logic [LEFT_W-1:0] chk_left;
	logic [15:0]       word;
	logic [15:0]       dlen;
	logic [16:0]       plen;
	logic [16:0]       orig;
	logic [PAD_W-1:0]  pad_dec;

	assign in_ready  = !out_valid_q || out_ready;
	assign fire      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign word    = {in_data.rx_byte, lo_q};
	assign dlen    = word & cfg.length_field_mask;
	assign plen    = {1'b0, dlen} + 17'(PACKET_OVERHEAD);
	assign orig    = 17'(left_q) + 17'd2;
	assign pad_dec = pad_q - 1'b1;

	always_comb begin
		ph_d      = ph_q;
		left_d    = left_q;
		pay_d     = pay_q;
		lo_d      = lo_q;
		pad_d     = pad_q;
		stream_d  = stream_q;
		started_d = started_q;
		emit      = 1'b0;
		res       = '0;
		do_after  = 1'b0;
		chk_left  = left_q;

		if (in_data.frame_begin) begin
			if (in_data.rx_byte == cfg.frame_start_byte) begin
				ph_d = PH_FLEN_LO;
			end else begin
				ph_d             = PH_IDLE;
				emit             = 1'b1;
				res.frame_done   = 1'b1;
				res.frame_status = ST_SKIPPED;
			end
		end else begin
			unique case (ph_q)
				PH_IDLE: begin
				end
				PH_FLEN_LO: begin
					lo_d = in_data.rx_byte;
					ph_d = PH_FLEN_HI;
				end
				PH_FLEN_HI: begin
					// used length must fit the data area of the frame
					if (word == 16'd0 || word > 16'(FRAME_BYTES - 3)) begin
						ph_d             = PH_IDLE;
						emit             = 1'b1;
						res.frame_done   = 1'b1;
						res.frame_status = ST_SKIPPED;
					end else begin
						left_d   = word[LEFT_W-1:0];
						chk_left = word[LEFT_W-1:0];
						do_after = 1'b1;
					end
				end
				PH_SOP: begin
					if (in_data.rx_byte != cfg.packet_start_byte) begin
						ph_d             = PH_IDLE;
						emit             = 1'b1;
						res.frame_done   = 1'b1;
						res.frame_status = ST_TRAILING;
					end else begin
						left_d = left_q - 1'b1;
						ph_d   = PH_HDR_LO;
					end
				end
				PH_HDR_LO: begin
					lo_d   = in_data.rx_byte;
					left_d = left_q - 1'b1;
					ph_d   = PH_HDR_HI;
				end
				PH_HDR_HI: begin
					// truncation is checked before the size limit
					if (orig < plen) begin
						ph_d             = PH_IDLE;
						emit             = 1'b1;
						res.frame_done   = 1'b1;
						res.frame_status = ST_TRUNCATED;
					end else if (plen > {1'b0, cfg.max_packet_bytes}) begin
						ph_d             = PH_IDLE;
						emit             = 1'b1;
						res.frame_done   = 1'b1;
						res.frame_status = ST_TOO_LONG;
					end else begin
						left_d    = left_q - 1'b1;
						pay_d     = dlen[LEFT_W-1:0];
						stream_d  = (word & cfg.stream_flag_mask) != 16'd0;
						started_d = 1'b0;
						if (PACKET_OVERHEAD > 3) begin
							pad_d = PAD_W'(PACKET_OVERHEAD - 3);
							ph_d  = PH_PAD;
						end else if (dlen == 16'd0) begin
							chk_left = left_q - 1'b1;
							do_after = 1'b1;
						end else begin
							ph_d = PH_DATA;
						end
					end
				end
				PH_PAD: begin
					left_d = left_q - 1'b1;
					pad_d  = pad_dec;
					if (pad_dec == '0) begin
						if (pay_q == '0) begin
							chk_left = left_q - 1'b1;
							do_after = 1'b1;
						end else begin
							ph_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					started_d         = 1'b1;
					left_d            = left_q - 1'b1;
					pay_d             = pay_q - 1'b1;
					emit              = 1'b1;
					res.payload_byte  = in_data.rx_byte;
					res.byte_valid    = 1'b1;
					res.packet_first  = !started_q;
					res.packet_last   = (pay_d == '0);
					res.stream_packet = stream_q;
					if (pay_d == '0) begin
						chk_left = left_q - 1'b1;
						do_after = 1'b1;
					end
				end
				default: begin
				end
			endcase

			// what follows the frame header or a finished packet
			if (do_after) begin
				if (chk_left == '0) begin
					ph_d             = PH_IDLE;
					emit             = 1'b1;
					res.frame_done   = 1'b1;
					res.frame_status = ST_OK;
				end else if (chk_left <= LEFT_W'(PACKET_OVERHEAD)) begin
					ph_d             = PH_IDLE;
					emit             = 1'b1;
					res.frame_done   = 1'b1;
					res.frame_status = ST_TRAILING;
				end else begin
					ph_d = PH_SOP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_IDLE;
			left_q      <= '0;
			pay_q       <= '0;
			lo_q        <= '0;
			pad_q       <= '0;
			stream_q    <= 1'b0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				ph_q      <= ph_d;
				left_q    <= left_d;
				pay_q     <= pay_d;
				lo_q      <= lo_d;
				pad_q     <= pad_d;
				stream_q  <= stream_d;
				started_q <= started_d;
			end
			if (fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_data_q <= res;
		end
	end

endmodule

// ===== rtl/spi_frame_packet_deframer_top.sv =====
// byte-serial deframer for fixed-size spi receive frames
// in channel: one received byte per request with a frame_begin mark on the
// first byte of each frame. a frame is a start byte, a little-endian used
// length and data; inside the used length packets of start byte, header word,
// optional pad bytes and payload are unpacked
// out channel: zero or one result per input byte: a payload byte with
// first/last/stream marks, and/or a frame_done flag with its status
// latency: a result is registered on the edge that takes its byte and is
// offered on out_valid in the next cycle
// throughput: one byte per cycle while the receiver takes results; the whole parse step is one
// pass of logic from the parse state registers to the result register
// receiver stall: the result register holds; a new byte is still taken in the
// cycle the held result is taken, otherwise in_ready drops
// reset: parser idles until a frame_begin byte arrives, output register is
// empty, configuration registers return to their defaults
// configuration: cfg_wen/cfg_index/cfg_data, to be written only while idle; the block itself does not enforce it
module spi_frame_packet_deframer_top import sfpd_pkg::*; #(
	parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
	parameter int PACKET_OVERHEAD = PACKET_OVERHEAD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sfpd_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sfpd_out_t             out_data
);

	sfpd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_FRAME_START:  cfg_q.frame_start_byte  <= cfg_data[7:0];
				REG_PACKET_START: cfg_q.packet_start_byte <= cfg_data[7:0];
				REG_LENGTH_MASK:  cfg_q.length_field_mask <= cfg_data;
				REG_STREAM_MASK:  cfg_q.stream_flag_mask  <= cfg_data;
				REG_MAX_PACKET:   cfg_q.max_packet_bytes  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sfpd_parser #(
		.FRAME_BYTES     (FRAME_BYTES),
		.PACKET_OVERHEAD (PACKET_OVERHEAD)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a result without a payload byte only ever reports the end of a frame
	a_empty_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.byte_valid |-> out_data.frame_done)
		else $error("result with neither byte nor frame end");

	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.frame_done |-> out_data.frame_status == ST_OK)
		else $error("status reported before frame end");

	a_marks_need_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.byte_valid |->
			!out_data.packet_first && !out_data.packet_last && !out_data.stream_packet)
		else $error("packet marks without payload byte");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("byte taken while result register is stalled");

endmodule
